// ===== sv/dsu_pkg.sv =====
`timescale 1ns / 1ps

package dsu_pkg;

   localparam int WORD_BITS = 32;
   localparam int WORD_CNT_W = $clog2(WORD_BITS + 1);

   // packing_mode codes
   localparam logic [1:0] MODE_PACKED   = 2'd0;
   localparam logic [1:0] MODE_FILLED_A = 2'd1;
   localparam logic [1:0] MODE_FILLED_B = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_PACKING_MODE     = 2'd0;
   localparam logic [1:0] CSR_BIT_DEPTH        = 2'd1;
   localparam logic [1:0] CSR_SWAP_BYTES       = 2'd2;
   localparam logic [1:0] CSR_SAMPLES_PER_LINE = 2'd3;

   localparam logic [9:0] FILLED_MASK = 10'h3FF;

   typedef enum logic [1:0] {
      KIND_PACKED,
      KIND_FILLED_A,
      KIND_FILLED_B
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [WORD_BITS-1:0]   word;
   } job_type;

   typedef struct packed {
      logic [1:0]  packing_mode;
      logic [4:0]  bit_depth;
      logic        swap_bytes;
      logic [15:0] samples_per_line;
   } cfg_type;

   // depth 0 behaves as 1, anything above 16 as 16
   function automatic logic [4:0] eff_depth(input logic [4:0] depth);
      logic [4:0] res;
      if (depth == 5'd0) begin
         res = 5'd1;
      end else if (depth > 5'd16) begin
         res = 5'd16;
      end else begin
         res = depth;
      end
      return res;
   endfunction

endpackage

// ===== sv/dpx_sample_unpacker.sv =====
`timescale 1ns / 1ps

// DPX sample unpacker: 32-bit image words in, 16-bit samples out, one sample
// per clock from the unpack engine unless rsp_stall holds it. A word yields
// three samples in filled modes A/B unless a line ends first, and up to 32 in
// packed 1-bit data; a packed sample never needs more than 16 bits, so every
// packed word completes at least one sample. Words taken in packing mode 3
// are dropped at the input. A
// QUEUE_DEPTH-entry queue sits between the input and the engine, and the
// sample output is registered, so the input keeps taking words while a
// sample waits. Registers may only be written while the block is idle;
// writing packing_mode or bit_depth drops any part-assembled packed sample.
module dpx_sample_unpacker #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dsu_pkg::WORD_BITS-1:0]  req_data_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [15:0]                    rsp_sample,
   output logic                           rsp_end_of_line,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [15:0]                    csr_wdata
);
   import dsu_pkg::*;

   cfg_type  cfg_ff;
   logic     csr_we;
   logic     clr_partial;
   logic     q_full, q_push, q_pop, q_valid;
   job_type  push_job, pop_job;

   assign csr_ready   = 1'b1;
   assign csr_we      = csr_valid && csr_ready;
   assign clr_partial = csr_we && ((csr_index == CSR_PACKING_MODE) ||
                                   (csr_index == CSR_BIT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packing_mode     <= MODE_PACKED;
         cfg_ff.bit_depth        <= 5'd10;
         cfg_ff.swap_bytes       <= 1'b0;
         cfg_ff.samples_per_line <= 16'd1920;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PACKING_MODE:     cfg_ff.packing_mode     <= csr_wdata[1:0];
            CSR_BIT_DEPTH:        cfg_ff.bit_depth        <= csr_wdata[4:0];
            CSR_SWAP_BYTES:       cfg_ff.swap_bytes       <= csr_wdata[0];
            CSR_SAMPLES_PER_LINE: cfg_ff.samples_per_line <= csr_wdata;
            default:              ;
         endcase
      end
   end

   dsu_front u_front (
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_data_word (req_data_word),
      .req_stall     (req_stall),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (push_job)
   );

   dsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (pop_job)
   );

   dsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .clr_partial     (clr_partial),
      .q_valid         (q_valid),
      .q_job           (pop_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_end_of_line (rsp_end_of_line),
      .rsp_last        (rsp_last)
   );

   // a line end always closes the word's beats
   a_eol_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_line |-> rsp_last)
      else $error("end of line without last");

   // packed samples carry only the high byte
   a_packed_low_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cfg_ff.packing_mode == MODE_PACKED) |-> rsp_sample[7:0] == 8'h00)
      else $error("packed sample with low byte set");

   // filled samples are 10 bits left-aligned
   a_filled_low_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((cfg_ff.packing_mode == MODE_FILLED_A) ||
                    (cfg_ff.packing_mode == MODE_FILLED_B))
      |-> rsp_sample[5:0] == 6'd0)
      else $error("filled sample not left-aligned");

   // no beat straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

// ===== sv/dsu_front.sv =====
`timescale 1ns / 1ps

module dsu_front (
   input  dsu_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   input  logic [dsu_pkg::WORD_BITS-1:0]  req_data_word,
   output logic                           req_stall,
   input  logic                           q_full,
   output logic                           q_push,
   output dsu_pkg::job_type               q_job
);
   import dsu_pkg::*;

   logic [WORD_BITS-1:0] word;
   logic                 keep;

   assign word = cfg.swap_bytes ?
                 {req_data_word[7:0], req_data_word[15:8],
                  req_data_word[23:16], req_data_word[31:24]} :
                 req_data_word;

   // mode 3 beats are taken and dropped here
   always_comb begin
      keep       = 1'b1;
      q_job.word = word;
      q_job.kind = KIND_PACKED;
      unique case (cfg.packing_mode)
         MODE_PACKED:   q_job.kind = KIND_PACKED;
         MODE_FILLED_A: q_job.kind = KIND_FILLED_A;
         MODE_FILLED_B: q_job.kind = KIND_FILLED_B;
         default:       keep = 1'b0;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && keep;

endmodule

// ===== sv/dsu_queue.sv =====
`timescale 1ns / 1ps

module dsu_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dsu_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output dsu_pkg::job_type  pop_job
);
   import dsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/dsu_back.sv =====
`timescale 1ns / 1ps

module dsu_back (
   input  logic              clock,
   input  logic              reset,
   input  dsu_pkg::cfg_type  cfg,
   input  logic              clr_partial,
   input  logic              q_valid,
   input  dsu_pkg::job_type  q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_sample,
   output logic              rsp_end_of_line,
   output logic              rsp_last
);
   import dsu_pkg::*;

   logic                   busy_ff, busy_in;
   kind_type               kind_ff, kind_in;
   logic [WORD_BITS-1:0]   rem_ff, rem_in;
   logic [WORD_CNT_W-1:0]  avail_ff, avail_in;
   logic [1:0]             idx_ff, idx_in;
   logic [15:0]            partial_ff, partial_in;
   logic [4:0]             pbits_ff, pbits_in;
   logic [15:0]            line_ff, line_in;
   logic                   out_valid_ff, out_valid_in;
   logic [15:0]            out_sample_ff, out_sample_in;
   logic                   out_eol_ff, out_eol_in;
   logic                   out_last_ff, out_last_in;

   logic                   step_en, done_now, load_en;
   logic [4:0]             n, need;
   logic                   fits;
   logic [15:0]            mask16, chunk, full_sample;
   logic [WORD_BITS-1:0]   rem_next;
   logic [WORD_CNT_W-1:0]  avail_next;
   logic [7:0]             v8;
   logic [16:0]            line_next, limit;
   logic                   eol;
   logic [4:0]             fshift;
   logic [WORD_BITS-1:0]   fword;

   assign n      = eff_depth(cfg.bit_depth);
   assign need   = n - pbits_ff;
   assign fits   = ({{(WORD_CNT_W-5){1'b0}}, need} <= avail_ff);
   assign mask16 = ~(16'hFFFF << need);
   assign chunk  = rem_ff[15:0] & mask16;
   assign full_sample = partial_ff | (chunk << pbits_ff);
   assign rem_next    = rem_ff >> need;
   assign avail_next  = avail_ff - WORD_CNT_W'(need);

   // reduce to 8 bits: drop low bits for deep samples, pad shallow ones
   always_comb begin
      if (n >= 5'd8) begin
         v8 = 8'(full_sample >> (n - 5'd8));
      end else begin
         v8 = 8'(full_sample << (5'd8 - n));
      end
   end

   assign line_next = {1'b0, line_ff} + 17'd1;
   assign limit     = (cfg.samples_per_line == 16'd0) ? 17'h10000 :
                      {1'b0, cfg.samples_per_line};
   assign eol       = (line_next >= limit);

   always_comb begin
      fshift = 5'd0;
      unique case ({kind_ff == KIND_FILLED_A, idx_ff})
         3'b1_00: fshift = 5'd22;
         3'b1_01: fshift = 5'd12;
         3'b1_10: fshift = 5'd2;
         3'b0_00: fshift = 5'd20;
         3'b0_01: fshift = 5'd10;
         3'b0_10: fshift = 5'd0;
         default: fshift = 5'd0;
      endcase
   end
   assign fword = rem_ff >> fshift;

   assign step_en = busy_ff && (!out_valid_ff || !rsp_stall);

   always_comb begin
      busy_in       = busy_ff;
      kind_in       = kind_ff;
      rem_in        = rem_ff;
      avail_in      = avail_ff;
      idx_in        = idx_ff;
      partial_in    = partial_ff;
      pbits_in      = pbits_ff;
      line_in       = line_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_sample_in = out_sample_ff;
      out_eol_in    = out_eol_ff;
      out_last_in   = out_last_ff;
      done_now      = 1'b0;

      if (step_en) begin
         if (kind_ff == KIND_PACKED) begin
            if (!fits) begin
               // word runs out before the sample is complete: keep its bits
               partial_in = partial_ff | 16'(rem_ff[15:0] << pbits_ff);
               pbits_in   = pbits_ff + 5'(avail_ff);
               done_now   = 1'b1;
            end else begin
               out_valid_in  = 1'b1;
               out_sample_in = {v8, 8'h00};
               out_eol_in    = eol;
               line_in       = eol ? 16'd0 : line_next[15:0];
               rem_in        = rem_next;
               avail_in      = avail_next;
               partial_in    = 16'd0;
               pbits_in      = 5'd0;
               if (eol || avail_next < WORD_CNT_W'(n)) begin
                  out_last_in = 1'b1;
                  done_now    = 1'b1;
                  if (!eol) begin
                     // leftover bits start the next sample; dropped at line end
                     partial_in = rem_next[15:0];
                     pbits_in   = 5'(avail_next);
                  end
               end else begin
                  out_last_in = 1'b0;
               end
            end
         end else begin
            out_valid_in  = 1'b1;
            out_sample_in = {fword[9:0] & FILLED_MASK, 6'd0};
            out_eol_in    = eol;
            out_last_in   = eol || (idx_ff == 2'd2);
            line_in       = eol ? 16'd0 : line_next[15:0];
            idx_in        = idx_ff + 2'd1;
            done_now      = eol || (idx_ff == 2'd2);
         end
      end

      load_en = q_valid && (!busy_ff || done_now);
      if (load_en) begin
         busy_in  = 1'b1;
         kind_in  = q_job.kind;
         rem_in   = q_job.word;
         avail_in = WORD_CNT_W'(WORD_BITS);
         idx_in   = 2'd0;
      end else if (done_now) begin
         busy_in = 1'b0;
      end

      if (clr_partial) begin
         partial_in = 16'd0;
         pbits_in   = 5'd0;
      end
   end

   assign q_pop = load_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         partial_ff   <= 16'd0;
         pbits_ff     <= 5'd0;
         line_ff      <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         partial_ff   <= partial_in;
         pbits_ff     <= pbits_in;
         line_ff      <= line_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff       <= kind_in;
      rem_ff        <= rem_in;
      avail_ff      <= avail_in;
      idx_ff        <= idx_in;
      out_sample_ff <= out_sample_in;
      out_eol_ff    <= out_eol_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_sample      = out_sample_ff;
   assign rsp_end_of_line = out_eol_ff;
   assign rsp_last        = out_last_ff;

endmodule
